// ===== rtl/e2q_pkg.sv =====
// ----------------------------------------------------------------------------
// e2q_pkg
// Shared types, constants and arithmetic helpers of the Euler to quaternion
// converter.
// ----------------------------------------------------------------------------
package e2q_pkg;

  typedef struct packed {
    logic signed [15:0] yaw_deg;
    logic signed [15:0] pitch_deg;
    logic signed [15:0] roll_deg;
  } in_t;

  typedef struct packed {
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic signed [15:0] quat_w;
  } out_t;

  // pipeline depth of each part
  localparam int PhaseStages  = 2;
  localparam int SinCosStages = 11;
  localparam int CombStages   = 3;
  localparam int PipeStages   = PhaseStages + SinCosStages + CombStages;

  // phase = round(|a| * 2^32 / (720 * 64)) = m * 93206 + floor((34 m + 22) / 45)
  // for 6 angle fraction bits
  localparam logic [32:0] PhaseMul        = 33'd93206;
  localparam logic [21:0] PhaseRecip      = 22'd2982617;
  localparam int          PhaseRecipShift = 27;

  localparam logic [30:0] One   = 31'(64'd1 << 30);
  localparam logic [31:0] PiQ30 = 32'd3373259426;
  localparam logic [29:0] OctSpan = 30'(64'd1 << 29);

  // exact divide of a value below 2^31 by a constant: (y * ceil(2^s / d)) >> s
  localparam logic [32:0] Recip72 = 33'(((64'd1 << 38) + 64'd71) / 64'd72);
  localparam logic [32:0] Recip42 = 33'(((64'd1 << 37) + 64'd41) / 64'd42);
  localparam logic [32:0] Recip20 = 33'(((64'd1 << 36) + 64'd19) / 64'd20);
  localparam logic [32:0] Recip6  = 33'(((64'd1 << 34) + 64'd5) / 64'd6);
  localparam logic [32:0] Recip90 = 33'(((64'd1 << 38) + 64'd89) / 64'd90);
  localparam logic [32:0] Recip56 = 33'(((64'd1 << 37) + 64'd55) / 64'd56);
  localparam logic [32:0] Recip30 = 33'(((64'd1 << 36) + 64'd29) / 64'd30);
  localparam logic [32:0] Recip12 = 33'(((64'd1 << 35) + 64'd11) / 64'd12);

  localparam logic [32:0] SinRecip [0:2] = '{Recip42, Recip20, Recip6};
  localparam logic [5:0]  SinShift [0:2] = '{6'd37, 6'd36, 6'd34};
  localparam logic [32:0] CosRecip [0:2] = '{Recip56, Recip30, Recip12};
  localparam logic [5:0]  CosShift [0:2] = '{6'd37, 6'd36, 6'd35};

  localparam int OutFracBits = 15;
  localparam int OutShift    = 30 - OutFracBits;
  localparam logic [32:0] OutMax = 33'd32767;

  function automatic logic [30:0] div_c(input logic [30:0] y, input logic [32:0] m,
                                        input logic [5:0] s);
    logic [63:0] p;
    p = 64'(y) * 64'(m);
    return 31'(p >> s);
  endfunction

  // unsigned Q2.30 product, truncated
  function automatic logic [30:0] mulq30(input logic [30:0] a, input logic [30:0] b);
    logic [61:0] p;
    p = 62'(a) * 62'(b);
    return p[60:30];
  endfunction

  // signed Q2.30 product, rounded half away from zero
  function automatic logic signed [31:0] mul30(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
    logic        neg;
    logic [31:0] ma;
    logic [31:0] mb;
    logic [63:0] p;
    logic [31:0] r;
    neg = a[31] ^ b[31];
    ma  = a[31] ? 32'(-a) : 32'(a);
    mb  = b[31] ? 32'(-b) : 32'(b);
    p   = 64'(ma) * 64'(mb) + (64'd1 << 29);
    r   = 32'(p >> 30);
    return neg ? -r : r;
  endfunction

  // round to output fraction bits and saturate the magnitude
  function automatic logic signed [15:0] to_out(input logic signed [32:0] v);
    logic        neg;
    logic [32:0] m;
    neg = v[32];
    m   = neg ? 33'(-v) : 33'(v);
    if (OutShift > 0) begin
      m = (m + (33'd1 << (OutShift - 1))) >> OutShift;
    end else begin
      m = m << (-OutShift);
    end
    if (m > OutMax) begin
      m = OutMax;
    end
    return neg ? -m[15:0] : m[15:0];
  endfunction

endpackage

// ===== rtl/e2q_phase.sv =====
// ----------------------------------------------------------------------------
// e2q_phase
// Half angle in degrees to a 32-bit turn phase, two register stages.
// ----------------------------------------------------------------------------
module e2q_phase (
  input  logic                                clk_i,
  input  logic [e2q_pkg::PhaseStages-1:0]     en_i,
  input  logic signed [15:0]                  angle_i,
  output logic [31:0]                         phase_o
);

  logic [15:0] mag;
  logic [20:0] y;
  logic [42:0] lo_p;
  logic        neg_q;
  logic [31:0] hi_q;
  logic [15:0] lo_q;
  logic [31:0] q_sum;
  logic [31:0] phase_q;

  assign mag  = angle_i[15] ? 16'(-angle_i) : 16'(angle_i);
  assign y    = 21'({mag, 5'b0}) + 21'({mag, 1'b0}) + 21'd22;
  assign lo_p = 43'(y) * 43'(e2q_pkg::PhaseRecip);

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      neg_q <= angle_i[15];
      hi_q  <= 32'(33'(mag) * e2q_pkg::PhaseMul);
      lo_q  <= 16'(lo_p >> e2q_pkg::PhaseRecipShift);
    end
  end

  assign q_sum = hi_q + 32'(lo_q);

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      phase_q <= neg_q ? -q_sum : q_sum;
    end
  end

  assign phase_o = phase_q;

endmodule

// ===== rtl/e2q_sincos.sv =====
// ----------------------------------------------------------------------------
// e2q_sincos
// Sine and cosine in Q2.30 of a turn phase: octant fold, then the two
// series evaluated one multiply or one divide per stage.
// ----------------------------------------------------------------------------
module e2q_sincos (
  input  logic                                clk_i,
  input  logic [e2q_pkg::SinCosStages-1:0]    en_i,
  input  logic [31:0]                         phase_i,
  output logic signed [31:0]                  sin_o,
  output logic signed [31:0]                  cos_o
);

  logic [2:0]  oct_q [0:9];
  logic [29:0] x_q   [0:8];
  logic [29:0] xx_q  [1:8];
  logic [30:0] ts_q  [0:3];
  logic [30:0] tc_q  [0:3];
  logic [30:0] ps_q  [0:2];
  logic [30:0] pc_q  [0:2];
  logic [30:0] sa_q;
  logic [30:0] pcf_q;
  logic signed [31:0] sin_q;
  logic signed [31:0] cos_q;

  logic [29:0] f_fold;
  logic [61:0] fx;
  logic [59:0] xsq;
  logic [30:0] ca;
  logic signed [31:0] s_v;
  logic signed [31:0] c_v;
  logic [3:0]  oct_p1;
  logic [3:0]  oct_p2;

  assign f_fold = phase_i[29] ? (e2q_pkg::OctSpan - 30'(phase_i[28:0]))
                              : 30'(phase_i[28:0]);
  assign fx     = 62'(f_fold) * 62'(e2q_pkg::PiQ30);
  assign xsq    = 60'(x_q[0]) * 60'(x_q[0]);

  // octant unfold: swap, then sign of each
  assign ca     = e2q_pkg::One - (pcf_q >> 1);
  assign oct_p1 = 4'(oct_q[9]) + 4'd1;
  assign oct_p2 = 4'(oct_q[9]) + 4'd2;

  always_comb begin
    s_v = oct_p1[1] ? 32'(ca) : 32'(sa_q);
    c_v = oct_p1[1] ? 32'(sa_q) : 32'(ca);
    if (oct_q[9][2]) begin
      s_v = -s_v;
    end
    if (oct_p2[2]) begin
      c_v = -c_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      oct_q[0] <= phase_i[31:29];
      x_q[0]   <= 30'(fx >> 31);
    end
    if (en_i[1]) begin
      xx_q[1] <= 30'(xsq >> 30);
    end
    if (en_i[2]) begin
      ts_q[0] <= e2q_pkg::One - e2q_pkg::div_c(31'(xx_q[1]), e2q_pkg::Recip72, 6'd38);
      tc_q[0] <= e2q_pkg::One - e2q_pkg::div_c(31'(xx_q[1]), e2q_pkg::Recip90, 6'd38);
    end
    // pass-through of octant, x and x squared
    for (int k = 1; k <= 9; k++) begin
      if (en_i[k]) begin
        oct_q[k] <= oct_q[k-1];
      end
    end
    for (int k = 1; k <= 8; k++) begin
      if (en_i[k]) begin
        x_q[k] <= x_q[k-1];
      end
    end
    for (int k = 2; k <= 8; k++) begin
      if (en_i[k]) begin
        xx_q[k] <= xx_q[k-1];
      end
    end
    // one series term: multiply stage, then divide and subtract stage
    for (int j = 0; j < 3; j++) begin
      if (en_i[3 + 2*j]) begin
        ps_q[j] <= e2q_pkg::mulq30(31'(xx_q[2 + 2*j]), ts_q[j]);
        pc_q[j] <= e2q_pkg::mulq30(31'(xx_q[2 + 2*j]), tc_q[j]);
      end
      if (en_i[4 + 2*j]) begin
        ts_q[j+1] <= e2q_pkg::One
                     - e2q_pkg::div_c(ps_q[j], e2q_pkg::SinRecip[j], e2q_pkg::SinShift[j]);
        tc_q[j+1] <= e2q_pkg::One
                     - e2q_pkg::div_c(pc_q[j], e2q_pkg::CosRecip[j], e2q_pkg::CosShift[j]);
      end
    end
    if (en_i[9]) begin
      sa_q  <= e2q_pkg::mulq30(31'(x_q[8]), ts_q[3]);
      pcf_q <= e2q_pkg::mulq30(31'(xx_q[8]), tc_q[3]);
    end
    if (en_i[10]) begin
      sin_q <= s_v;
      cos_q <= c_v;
    end
  end

  assign sin_o = sin_q;
  assign cos_o = cos_q;

endmodule

// ===== rtl/e2q_combine.sv =====
// ----------------------------------------------------------------------------
// e2q_combine
// ZYX product formulas: pair products, triple products, then sums rounded
// and saturated to the output format.
// ----------------------------------------------------------------------------
module e2q_combine (
  input  logic                              clk_i,
  input  logic [e2q_pkg::CombStages-1:0]    en_i,
  input  logic signed [31:0]                sy_i,
  input  logic signed [31:0]                cy_i,
  input  logic signed [31:0]                sp_i,
  input  logic signed [31:0]                cp_i,
  input  logic signed [31:0]                sr_i,
  input  logic signed [31:0]                cr_i,
  output e2q_pkg::out_t                     out_o
);

  logic signed [31:0] scp_q;
  logic signed [31:0] csp_q;
  logic signed [31:0] ccp_q;
  logic signed [31:0] ssp_q;
  logic signed [31:0] sy_q;
  logic signed [31:0] cy_q;
  logic signed [31:0] xa_q;
  logic signed [31:0] xb_q;
  logic signed [31:0] ya_q;
  logic signed [31:0] yb_q;
  logic signed [31:0] za_q;
  logic signed [31:0] zb_q;
  logic signed [31:0] wa_q;
  logic signed [31:0] wb_q;
  e2q_pkg::out_t      out_q;

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      scp_q <= e2q_pkg::mul30(sr_i, cp_i);
      csp_q <= e2q_pkg::mul30(cr_i, sp_i);
      ccp_q <= e2q_pkg::mul30(cr_i, cp_i);
      ssp_q <= e2q_pkg::mul30(sr_i, sp_i);
      sy_q  <= sy_i;
      cy_q  <= cy_i;
    end
    if (en_i[1]) begin
      xa_q <= e2q_pkg::mul30(scp_q, cy_q);
      xb_q <= e2q_pkg::mul30(csp_q, sy_q);
      ya_q <= e2q_pkg::mul30(csp_q, cy_q);
      yb_q <= e2q_pkg::mul30(scp_q, sy_q);
      za_q <= e2q_pkg::mul30(ccp_q, sy_q);
      zb_q <= e2q_pkg::mul30(ssp_q, cy_q);
      wa_q <= e2q_pkg::mul30(ccp_q, cy_q);
      wb_q <= e2q_pkg::mul30(ssp_q, sy_q);
    end
    if (en_i[2]) begin
      out_q.quat_x <= e2q_pkg::to_out(33'(xa_q) - 33'(xb_q));
      out_q.quat_y <= e2q_pkg::to_out(33'(ya_q) + 33'(yb_q));
      out_q.quat_z <= e2q_pkg::to_out(33'(za_q) - 33'(zb_q));
      out_q.quat_w <= e2q_pkg::to_out(33'(wa_q) + 33'(wb_q));
    end
  end

  assign out_o = out_q;

endmodule

// ===== rtl/euler_to_quaternion_core.sv =====
// ----------------------------------------------------------------------------
// euler_to_quaternion_core
// Yaw, pitch and roll in degrees to a unit quaternion in Q1.15.
// ----------------------------------------------------------------------------
// One beat in, one beat out. The datapath is a 16-stage pipeline (2 stages
// of phase conversion, 11 of sine and cosine series, 3 of products and
// output rounding), and a new beat is taken every cycle while in_stall_o
// is low. Each stage holds its data while the one after it is full and
// stalled, so a stall at the output fills empty stages first and only
// then reaches in_stall_o.
module euler_to_quaternion_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  e2q_pkg::in_t     in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output e2q_pkg::out_t    out_data_o
);

  localparam int NStg = e2q_pkg::PipeStages;
  localparam int ScLo = e2q_pkg::PhaseStages;
  localparam int CbLo = e2q_pkg::PhaseStages + e2q_pkg::SinCosStages;

  logic [NStg-1:0] vld_q;
  logic [NStg-1:0] vld_d;
  logic [NStg-1:0] rdy;

  logic [31:0]        ph_y, ph_p, ph_r;
  logic signed [31:0] sy, cy, sp, cp, sr, cr;

  // a stage may load when it is empty or its content moves on
  always_comb begin
    rdy[NStg-1] = !vld_q[NStg-1] || !out_stall_i;
    for (int k = NStg - 2; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
  end

  always_comb begin
    for (int k = 0; k < NStg; k++) begin
      if (rdy[k]) begin
        vld_d[k] = (k == 0) ? in_valid_i : vld_q[(k == 0) ? 0 : k - 1];
      end else begin
        vld_d[k] = vld_q[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign in_stall_o  = !rdy[0];
  assign out_valid_o = vld_q[NStg-1];

  e2q_phase u_phase_y (
    .clk_i   (clk_i),
    .en_i    (rdy[ScLo-1:0]),
    .angle_i (in_data_i.yaw_deg),
    .phase_o (ph_y)
  );

  e2q_phase u_phase_p (
    .clk_i   (clk_i),
    .en_i    (rdy[ScLo-1:0]),
    .angle_i (in_data_i.pitch_deg),
    .phase_o (ph_p)
  );

  e2q_phase u_phase_r (
    .clk_i   (clk_i),
    .en_i    (rdy[ScLo-1:0]),
    .angle_i (in_data_i.roll_deg),
    .phase_o (ph_r)
  );

  e2q_sincos u_sc_y (
    .clk_i   (clk_i),
    .en_i    (rdy[CbLo-1:ScLo]),
    .phase_i (ph_y),
    .sin_o   (sy),
    .cos_o   (cy)
  );

  e2q_sincos u_sc_p (
    .clk_i   (clk_i),
    .en_i    (rdy[CbLo-1:ScLo]),
    .phase_i (ph_p),
    .sin_o   (sp),
    .cos_o   (cp)
  );

  e2q_sincos u_sc_r (
    .clk_i   (clk_i),
    .en_i    (rdy[CbLo-1:ScLo]),
    .phase_i (ph_r),
    .sin_o   (sr),
    .cos_o   (cr)
  );

  e2q_combine u_comb (
    .clk_i (clk_i),
    .en_i  (rdy[NStg-1:CbLo]),
    .sy_i  (sy),
    .cy_i  (cy),
    .sp_i  (sp),
    .cp_i  (cp),
    .sr_i  (sr),
    .cr_i  (cr),
    .out_o (out_data_o)
  );

endmodule

// ===== test/e2q_checker.sv =====
// ----------------------------------------------------------------------------
// e2q_checker
// Watches both channels of the Euler to quaternion converter, predicts each
// quaternion from the accepted angles and compares it with the output beat.
// ----------------------------------------------------------------------------
module e2q_checker (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_stall_i,
  input  e2q_pkg::in_t  in_data_i,
  input  logic          out_valid_i,
  input  logic          out_stall_i,
  input  e2q_pkg::out_t out_data_i,
  output int            fail_count_o,
  output int            pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint QOne    = 64'sd1 << 30;
  localparam longint PiQ30   = 64'sd3373259426;
  localparam longint OctSpan = 64'sd1 << 29;
  localparam int     AngFrac = 6;
  localparam int     OutFrac = 15;

  e2q_pkg::out_t quat_queue[$];
  int fails;

  assign fail_count_o = fails;
  assign pending_o    = quat_queue.size();

  function automatic longint qmul(longint a, longint b);
    logic neg;
    longint ma, mb, r;
    neg = (a < 0) != (b < 0);
    ma  = (a < 0) ? -a : a;
    mb  = (b < 0) ? -b : b;
    r   = (ma * mb + (64'sd1 << 29)) >>> 30;
    return neg ? -r : r;
  endfunction

  function automatic logic [31:0] angle_phase(logic signed [15:0] a);
    longint d, m, q;
    logic [31:0] p;
    d = 64'sd720 << AngFrac;
    m = (a < 0) ? -longint'(a) : longint'(a);
    q = ((m << 32) + d / 2) / d;
    p = q[31:0];
    return (a < 0) ? -p : p;
  endfunction

  function automatic void phase_sincos(input logic [31:0] ph, output longint s,
                                       output longint c);
    logic [2:0] oct;
    longint f, x, x2, t, tmp;
    oct = ph[31:29];
    f   = longint'(ph[28:0]);
    if (oct[0]) f = OctSpan - f;
    x  = (f * PiQ30) >>> 31;
    x2 = (x * x) >>> 30;
    t = QOne - x2 / 72;
    t = QOne - ((x2 * t) >>> 30) / 42;
    t = QOne - ((x2 * t) >>> 30) / 20;
    t = QOne - ((x2 * t) >>> 30) / 6;
    s = (x * t) >>> 30;
    t = QOne - x2 / 90;
    t = QOne - ((x2 * t) >>> 30) / 56;
    t = QOne - ((x2 * t) >>> 30) / 30;
    t = QOne - ((x2 * t) >>> 30) / 12;
    c = QOne - ((x2 * t) >>> 30) / 2;
    // octants 1,2,5,6 swap sine and cosine
    if (((oct + 3'd1) >> 1) & 3'd1) begin
      tmp = s;
      s = c;
      c = tmp;
    end
    if (oct >= 4) s = -s;
    if (((oct + 3'd2) >> 2) & 3'd1) c = -c;
  endfunction

  function automatic logic signed [15:0] round_q15(longint v);
    logic neg;
    longint m;
    neg = v < 0;
    m   = neg ? -v : v;
    m   = (m + (64'sd1 << (30 - OutFrac - 1))) >>> (30 - OutFrac);
    if (m > 32767) m = 32767;
    return neg ? 16'(-m) : 16'(m);
  endfunction

  function automatic e2q_pkg::out_t euler_quat(e2q_pkg::in_t a);
    longint sy, cy, sp, cp, sr, cr;
    e2q_pkg::out_t q;
    phase_sincos(angle_phase(a.yaw_deg), sy, cy);
    phase_sincos(angle_phase(a.pitch_deg), sp, cp);
    phase_sincos(angle_phase(a.roll_deg), sr, cr);
    q.quat_x = round_q15(qmul(qmul(sr, cp), cy) - qmul(qmul(cr, sp), sy));
    q.quat_y = round_q15(qmul(qmul(cr, sp), cy) + qmul(qmul(sr, cp), sy));
    q.quat_z = round_q15(qmul(qmul(cr, cp), sy) - qmul(qmul(sr, sp), cy));
    q.quat_w = round_q15(qmul(qmul(cr, cp), cy) + qmul(qmul(sr, sp), sy));
    return q;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    e2q_pkg::out_t exp_q;
    if (!rst_ni) begin
      fails = 0;
      quat_queue.delete();
    end else begin
      if (in_valid_i && !in_stall_i) begin
        quat_queue.push_back(euler_quat(in_data_i));
      end
      if (out_valid_i && !out_stall_i) begin
        if (quat_queue.size() == 0) begin
          $display("%0t: unexpected beat %h", $time, out_data_i);
          fails++;
        end else begin
          exp_q = quat_queue.pop_front();
          if (exp_q.quat_x !== out_data_i.quat_x) begin
            $display("%0t: quat_x expected %0d actual %0d", $time, exp_q.quat_x,
                     out_data_i.quat_x);
            fails++;
          end
          if (exp_q.quat_y !== out_data_i.quat_y) begin
            $display("%0t: quat_y expected %0d actual %0d", $time, exp_q.quat_y,
                     out_data_i.quat_y);
            fails++;
          end
          if (exp_q.quat_z !== out_data_i.quat_z) begin
            $display("%0t: quat_z expected %0d actual %0d", $time, exp_q.quat_z,
                     out_data_i.quat_z);
            fails++;
          end
          if (exp_q.quat_w !== out_data_i.quat_w) begin
            $display("%0t: quat_w expected %0d actual %0d", $time, exp_q.quat_w,
                     out_data_i.quat_w);
            fails++;
          end
        end
      end
    end
  end

endmodule

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives angle beats into the Euler to quaternion converter with random gaps
// and output stalls; the checker predicts and compares every quaternion.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NumRandom = 1900;
  localparam int MaxCycles = 400000;

  logic          clk;
  logic          rst_n;
  logic          in_valid;
  logic          in_stall;
  e2q_pkg::in_t  in_data;
  logic          out_valid;
  logic          out_stall;
  e2q_pkg::out_t out_data;
  int            fail_count;
  int            pending;
  int            cycle_count;
  logic          stall_busy;

  euler_to_quaternion_core u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  e2q_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_data_i   (out_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > MaxCycles) begin
      $display("testbench failed");
      $finish;
    end
  end

  function automatic logic signed [15:0] rand_angle();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return 16'($urandom);
    if (sel == 1) return 16'(int'($urandom_range(0, 46080)) - 23040);
    if (sel == 2) return 16'(int'($urandom_range(0, 8)) * 2880 - 11520);
    return 16'(int'($urandom_range(0, 46080)) - 23040);
  endfunction

  // random output stalls, redrawn per beat; quiet stretches now and then
  always @(posedge clk) begin
    if (rst_n && !stall_busy) begin
      stall_busy = 1'b1;
      fork
        begin
          int gap;
          gap = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(0, 17);
          if ($urandom_range(0, 3) != 0) gap = 0;
          out_stall <= (gap != 0);
          repeat (gap) @(posedge clk);
          out_stall <= 1'b0;
          while (!(out_valid && !out_stall)) @(posedge clk);
          stall_busy = 1'b0;
        end
      join_none
    end
  end

  task automatic send_beat(input logic signed [15:0] yaw, input logic signed [15:0] pitch,
                           input logic signed [15:0] roll, input int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{yaw_deg: yaw, pitch_deg: pitch, roll_deg: roll};
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  initial begin
    logic signed [15:0] dir_vals [0:9];
    int gap;
    dir_vals = '{16'sd0, 16'sd23040, -16'sd23040, 16'sd5760, -16'sd5760, 16'sd11520,
                 16'sd32767, -16'sd32768, 16'sd1, -16'sd1};
    stall_busy  = 1'b0;
    cycle_count = 0;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    out_stall = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int i = 0; i < 10; i++) begin
      send_beat(dir_vals[i], dir_vals[(i + 3) % 10], dir_vals[(i + 7) % 10], 0);
    end
    send_beat(16'sd23040, 16'sd23040, 16'sd23040, 1);
    send_beat(-16'sd23040, -16'sd23040, -16'sd23040, 0);
    send_beat(16'sd11520, 16'sd0, 16'sd0, 0);
    send_beat(16'sd0, 16'sd11520, 16'sd0, 0);
    send_beat(16'sd0, 16'sd0, 16'sd11520, 0);
    send_beat(16'sd17280, -16'sd17280, 16'sd8640, 2);
    for (int i = 0; i < NumRandom; i++) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 17) : 0;
      if ((i / 200) % 3 == 2) gap = 0;
      send_beat(rand_angle(), rand_angle(), rand_angle(), gap);
      // let the pipeline drain completely once
      if (i == NumRandom / 2) begin
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
      end
    end
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
